/* hw/rtl/wfir_pkg.sv */
// Shared types, constants and the Hann taper table of the stereo FIR filter.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package wfir_pkg;

  // Fixed field widths
  localparam int SAMPLE_W    = 24;
  localparam int COEF_W      = 16;
  localparam int COEF_SLOTS  = 16;
  localparam int TAP_IDX_W   = 4;
  localparam int WIN_W       = 5;
  localparam int RATIO_W     = 17;
  localparam int RATIO_FRAC  = 16;
  localparam int CE_W        = 25;
  localparam int OUT_SHIFT   = 23;
  localparam int TAP_COUNT_DEF = 16;

  localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(1 << RATIO_FRAC);

  // Taper table: one row of COEF_SLOTS weights per window size
  localparam int HANN_DEPTH = COEF_SLOTS * COEF_SLOTS;
  localparam int HANN_AW    = $clog2(HANN_DEPTH);

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = RATIO_W;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_HANN_RATIO  = CFG_IDX_W'(1);

  // Item commands
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_COEF   = 1'b1;

  typedef struct packed {
    logic                        cmd;
    logic signed [SAMPLE_W-1:0]  left_sample;
    logic signed [SAMPLE_W-1:0]  right_sample;
    logic [TAP_IDX_W-1:0]        tap_index;
    logic signed [COEF_W-1:0]    tap_value;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0]  left_out;
    logic signed [SAMPLE_W-1:0]  right_out;
  } out_item_t;

  // Coefficient store write request
  typedef struct packed {
    logic                      en;
    logic [TAP_IDX_W-1:0]      idx;
    logic signed [COEF_W-1:0]  value;
  } coef_wr_t;

  // Per-tap read request into the coefficient/taper pipeline
  typedef struct packed {
    logic                  vld;
    logic [TAP_IDX_W-1:0]  tap;
    logic [WIN_W-1:0]      taps;
    logic [RATIO_W-1:0]    ratio;
  } coef_rd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FIN
  } wfir_state_t;

  typedef logic [HANN_DEPTH-1:0][RATIO_W-1:0] hann_rom_t;

  // Elaboration-time helpers for building the taper table
  localparam longint     Q30_ONE = longint'(1) <<< 30;
  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  function automatic logic [63:0] div_u64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] q;
    logic [63:0] rem;
    q   = '0;
    rem = '0;
    for (int j = 63; j >= 0; j--) begin
      rem = {rem[62:0], a[j]};
      if (rem >= b) begin
        rem  = rem - b;
        q[j] = 1'b1;
      end
    end
    return q;
  endfunction

  // Signed quotient truncated towards zero, positive divisor
  function automatic longint div_trunc(input longint a, input longint b);
    logic [63:0] mag;
    logic [63:0] q;
    mag = (a < 0) ? 64'(-a) : 64'(a);
    q   = div_u64(mag, 64'(b));
    return (a < 0) ? -longint'(q) : longint'(q);
  endfunction

  // Weight 0.5*(1+cos(pi*i/n)) in Q1.16 via a Q30 Taylor series
  function automatic logic [RATIO_W-1:0] hann_weight(input int i, input int n);
    longint      num;
    longint      sum;
    longint      term;
    longint      h;
    logic [63:0] x;
    logic [63:0] x2;
    logic        flip;
    num  = longint'(i);
    flip = 1'b0;
    if (2 * i > n) begin
      num  = longint'(n - i);
      flip = 1'b1;
    end
    x    = div_u64(PI_Q30 * 64'(num), 64'(n));
    x2   = (x * x) >> 30;
    sum  = Q30_ONE;
    term = Q30_ONE;
    for (int k = 1; k <= 8; k++) begin
      term = div_trunc(term * longint'(x2), Q30_ONE);
      term = -div_trunc(term, longint'((2 * k - 1) * (2 * k)));
      sum  = sum + term;
    end
    h = flip ? (Q30_ONE - sum) : (Q30_ONE + sum);
    h = div_trunc(h, 2);
    if (h < 0) h = 0;
    if (h > Q30_ONE) h = Q30_ONE;
    return RATIO_W'((64'(h) + 64'd8192) >> 14);
  endfunction

  function automatic hann_rom_t hann_rom_build();
    hann_rom_t rom;
    rom = '0;
    for (int n = 1; n <= COEF_SLOTS; n++) begin
      for (int i = 0; i < COEF_SLOTS; i++) begin
        if (i < n) rom[(n - 1) * COEF_SLOTS + i] = hann_weight(i, n);
      end
    end
    return rom;
  endfunction

  localparam hann_rom_t HANN_ROM = hann_rom_build();

endpackage

`default_nettype wire

/* hw/rtl/wfir_coef.sv */
// Coefficient store and taper pipeline: turns a tap request into the tapered
// Q2.23 coefficient in its round register. Depends on wfir_pkg.
`default_nettype none

module wfir_coef (
  input  logic                             clk,
  input  logic                             rst_n,
  input  wfir_pkg::coef_wr_t               wr,
  input  wfir_pkg::coef_rd_t               rd,
  output logic signed [wfir_pkg::CE_W-1:0] ce
);
  import wfir_pkg::*;

  logic signed [COEF_W-1:0] coef_mem [COEF_SLOTS];
  logic [COEF_SLOTS-1:0]    coef_vld_r;
  logic [COEF_SLOTS-1:0]    coef_vld_nxt;

  logic signed [COEF_W-1:0] coef_q_r;
  logic                     cvld_r;
  logic [2*RATIO_W-1:0]     wr_r;
  logic [RATIO_W-1:0]       ratio1_r;
  logic signed [COEF_W-1:0] c_r;
  logic [RATIO_W-1:0]       f_r;
  logic signed [COEF_W+RATIO_W:0] cf_r;
  logic signed [CE_W-1:0]   ce_r;

  logic [WIN_W-1:0]         taps_m1;
  logic [HANN_AW-1:0]       rom_idx;
  logic [RATIO_W-1:0]       weight;
  logic [2*RATIO_W-1:0]     fsum;
  logic signed [COEF_W+RATIO_W:0] cf_rnd;

  always_comb begin
    coef_vld_nxt = coef_vld_r;
    if (wr.en) coef_vld_nxt[wr.idx] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_vld_r <= '0;
    end else begin
      coef_vld_r <= coef_vld_nxt;
    end
  end

  // Writes happen only between samples, so no read can overlap a write
  always_ff @(posedge clk) begin
    if (wr.en) coef_mem[wr.idx] <= wr.value;
    if (rd.vld) begin
      coef_q_r <= coef_mem[rd.tap];
      cvld_r   <= coef_vld_r[rd.tap];
    end
  end

  assign taps_m1 = rd.taps - WIN_W'(1);
  assign rom_idx = {taps_m1[TAP_IDX_W-1:0], rd.tap};
  assign weight  = HANN_ROM[rom_idx];

  assign fsum   = wr_r + {1'b0, (RATIO_ONE - ratio1_r), RATIO_FRAC'(0)}
                + (2*RATIO_W)'(1 << (RATIO_FRAC - 1));
  assign cf_rnd = cf_r + (COEF_W+RATIO_W+1)'(128);

  // Stage 0 weight*ratio, stage 1 blend factor, stage 2 scale, stage 3 round
  always_ff @(posedge clk) begin
    wr_r     <= weight * rd.ratio;
    ratio1_r <= rd.ratio;
    c_r      <= cvld_r ? coef_q_r : '0;
    f_r      <= fsum[RATIO_FRAC +: RATIO_W];
    cf_r     <= c_r * signed'({1'b0, f_r});
    ce_r     <= cf_rnd[8 +: CE_W];
  end

  assign ce = ce_r;

endmodule

`default_nettype wire

/* hw/rtl/windowed_fir_filter_stereo.sv */
// Stereo FIR filter with Hann-tapered coefficients, histories in block memory.
// A sample transaction with n active taps reads them in turn, drains the tap
// pipeline and loads the output register (straight to the output when n is zero).
// Throughput: one tap per cycle; no new item is taken while a sample is in work,
// and a result stalled at the output holds off the next one.
// Reset (synchronous, rst_n low): control registers clear; stored data reads as zero.
`default_nettype none

module windowed_fir_filter_stereo #(
  parameter int TAP_COUNT = wfir_pkg::TAP_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  wfir_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output wfir_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [wfir_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wfir_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import wfir_pkg::*;

  localparam int PTR_W   = $clog2(TAP_COUNT);
  localparam int AW      = PTR_W + 1;
  localparam int FILL_W  = $clog2(TAP_COUNT + 1);
  localparam int CW      = (FILL_W > TAP_IDX_W) ? FILL_W : TAP_IDX_W;
  localparam int MAX_N   = (TAP_COUNT < COEF_SLOTS) ? TAP_COUNT : COEF_SLOTS;
  localparam int PIPE_D  = 5;
  localparam int PROD_W  = SAMPLE_W + CE_W;
  localparam int ACC_W   = PROD_W + TAP_IDX_W;

  localparam logic signed [ACC_W-1:0] OUT_RND  = ACC_W'(64'd1 << (OUT_SHIFT - 1));
  localparam logic signed [ACC_W-1:0] OUT_MAX  = ACC_W'((64'd1 << (SAMPLE_W - 1)) - 64'd1);
  localparam logic signed [ACC_W-1:0] OUT_MIN  = -OUT_MAX - ACC_W'(1);

  // ---------------------------------------------------------------------------
  // Configuration registers: always writable, the block is idle by contract
  // ---------------------------------------------------------------------------
  logic [WIN_W-1:0]   win_r;
  logic [RATIO_W-1:0] ratio_r;
  logic [WIN_W-1:0]   n_eff;
  logic [RATIO_W-1:0] r_eff;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r   <= '0;
      ratio_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WINDOW_SIZE: win_r   <= cfg_wdata[WIN_W-1:0];
        CFG_HANN_RATIO:  ratio_r <= cfg_wdata[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the window to the stored taps and the ratio to one
  assign n_eff = (win_r > WIN_W'(MAX_N)) ? WIN_W'(MAX_N) : win_r;
  assign r_eff = (ratio_r > RATIO_ONE) ? RATIO_ONE : ratio_r;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  wfir_state_t state_r, state_nxt;

  logic in_acc;
  logic smp_acc;
  logic coef_acc;
  logic issue;
  logic out_load;
  logic out_take;
  logic last_tap;
  logic pipe_empty;

  logic [TAP_IDX_W-1:0] k_r, k_nxt;
  logic [PTR_W-1:0]     wp_r, wp_nxt;
  logic [FILL_W-1:0]    fill_r, fill_nxt;
  logic [PIPE_D-1:0]    pipe_vld_r, pipe_vld_nxt;
  logic                 out_valid_r, out_valid_nxt;

  assign in_acc     = in_valid && !in_stall;
  assign smp_acc    = in_acc && (in_data.cmd == CMD_SAMPLE);
  assign coef_acc   = in_acc && (in_data.cmd == CMD_COEF);
  assign out_take   = out_valid_r && !out_stall;
  assign last_tap   = (WIN_W'(k_r) == n_eff - WIN_W'(1));
  assign pipe_empty = (pipe_vld_r == '0);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (smp_acc) state_nxt = (n_eff == '0) ? ST_FIN : ST_RUN;
      end
      ST_RUN: begin
        if (last_tap) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (pipe_empty) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_stall = 1'b1;
    issue    = 1'b0;
    out_load = 1'b0;
    case (state_r)
      ST_IDLE:  in_stall = 1'b0;
      ST_RUN:   issue    = 1'b1;
      ST_DRAIN: ;
      ST_FIN:   out_load = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  always_comb begin
    k_nxt = k_r;
    if (smp_acc) k_nxt = '0;
    else if (issue) k_nxt = k_r + TAP_IDX_W'(1);

    // Pointer advances once the sample's taps are all read
    wp_nxt = wp_r;
    if (out_load) wp_nxt = (wp_r == PTR_W'(TAP_COUNT - 1)) ? '0 : wp_r + PTR_W'(1);

    fill_nxt = fill_r;
    if (smp_acc && (fill_r != FILL_W'(TAP_COUNT))) fill_nxt = fill_r + FILL_W'(1);

    pipe_vld_nxt = {pipe_vld_r[PIPE_D-2:0], issue};

    out_valid_nxt = out_valid_r;
    if (out_load) out_valid_nxt = 1'b1;
    else if (out_take) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= '0;
      wp_r        <= '0;
      fill_r      <= '0;
      pipe_vld_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      wp_r        <= wp_nxt;
      fill_r      <= fill_nxt;
      pipe_vld_r  <= pipe_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // History memories: write at the pointer on acceptance, read one tap a cycle
  // walking back from the pointer. The write lands in the cycle before tap 0 reads.
  // Entries never written since reset are masked to zero via the fill count.
  // ---------------------------------------------------------------------------
  logic signed [SAMPLE_W-1:0] hist_l_mem [TAP_COUNT];
  logic signed [SAMPLE_W-1:0] hist_r_mem [TAP_COUNT];

  logic [AW-1:0]    wp_x;
  logic [AW-1:0]    k_x;
  logic [AW-1:0]    addr_x;
  logic [PTR_W-1:0] rd_addr;
  logic             hvld;

  assign wp_x    = {1'b0, wp_r};
  assign k_x     = AW'(k_r);
  assign addr_x  = (wp_x >= k_x) ? (wp_x - k_x) : (wp_x + AW'(TAP_COUNT) - k_x);
  assign rd_addr = addr_x[PTR_W-1:0];
  assign hvld    = (CW'(k_r) < CW'(fill_r));

  logic signed [SAMPLE_W-1:0] hist_l_q_r, hist_r_q_r;
  logic                       hv_r;

  always_ff @(posedge clk) begin
    if (smp_acc) begin
      hist_l_mem[wp_r] <= in_data.left_sample;
      hist_r_mem[wp_r] <= in_data.right_sample;
    end
    if (issue) begin
      hist_l_q_r <= hist_l_mem[rd_addr];
      hist_r_q_r <= hist_r_mem[rd_addr];
      hv_r       <= hvld;
    end
  end

  // ---------------------------------------------------------------------------
  // Coefficient store and taper: the tapered coefficient arrives in step with the delayed history
  // ---------------------------------------------------------------------------
  coef_wr_t              coef_wr;
  coef_rd_t              coef_rd;
  logic signed [CE_W-1:0] ce;

  always_comb begin
    coef_wr.en    = coef_acc;
    coef_wr.idx   = in_data.tap_index;
    coef_wr.value = in_data.tap_value;
    coef_rd.vld   = issue;
    coef_rd.tap   = k_r;
    coef_rd.taps  = n_eff;
    coef_rd.ratio = r_eff;
  end

  wfir_coef u_coef (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (coef_wr),
    .rd    (coef_rd),
    .ce    (ce)
  );

  // ---------------------------------------------------------------------------
  // MAC: delay history data to meet the coefficient, multiply, accumulate
  // ---------------------------------------------------------------------------
  logic signed [SAMPLE_W-1:0] h1_l_r, h1_r_r, h2_l_r, h2_r_r, h3_l_r, h3_r_r;
  logic signed [PROD_W-1:0]   pl_r, pr_r, pl_nxt, pr_nxt;
  logic signed [ACC_W-1:0]    acc_l_r, acc_r_r, acc_l_nxt, acc_r_nxt;

  assign pl_nxt = h3_l_r * ce;
  assign pr_nxt = h3_r_r * ce;

  always_ff @(posedge clk) begin
    h1_l_r <= hv_r ? hist_l_q_r : '0;
    h1_r_r <= hv_r ? hist_r_q_r : '0;
    h2_l_r <= h1_l_r;
    h2_r_r <= h1_r_r;
    h3_l_r <= h2_l_r;
    h3_r_r <= h2_r_r;
    pl_r   <= pl_nxt;
    pr_r   <= pr_nxt;
  end

  always_comb begin
    acc_l_nxt = acc_l_r;
    acc_r_nxt = acc_r_r;
    if (smp_acc) begin
      acc_l_nxt = '0;
      acc_r_nxt = '0;
    end else if (pipe_vld_r[PIPE_D-1]) begin
      acc_l_nxt = acc_l_r + ACC_W'(pl_r);
      acc_r_nxt = acc_r_r + ACC_W'(pr_r);
    end
  end

  always_ff @(posedge clk) begin
    acc_l_r <= acc_l_nxt;
    acc_r_r <= acc_r_nxt;
  end

  // ---------------------------------------------------------------------------
  // Round half up to Q1.23, saturate, hold in the output register
  // ---------------------------------------------------------------------------
  function automatic logic signed [SAMPLE_W-1:0] round_sat(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] s;
    s = (a + OUT_RND) >>> OUT_SHIFT;
    if (s > OUT_MAX) s = OUT_MAX;
    if (s < OUT_MIN) s = OUT_MIN;
    return s[SAMPLE_W-1:0];
  endfunction

  out_item_t out_data_r;

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.left_out  <= round_sat(acc_l_r);
      out_data_r.right_out <= round_sat(acc_r_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // Taps in flight only while the sequencer is reading or draining
  a_pipe_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    (pipe_vld_r != '0) |-> (state_r == ST_RUN || state_r == ST_DRAIN))
    else $error("tap pipeline busy outside run/drain");

  // A coefficient transaction leaves the history pointer alone
  a_coef_keeps_wp: assert property (@(posedge clk) disable iff (!rst_n)
    coef_acc |=> $stable(wp_r))
    else $error("pointer moved on coefficient write");

  // A result is never loaded over one still waiting to be taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || !out_stall))
    else $error("output register overwritten");

  // Fill count never passes the history depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(TAP_COUNT))
    else $error("fill count overflow");
`endif

endmodule

`default_nettype wire
